FILE: rtl/lsc_pkg.sv
// Shared definitions for the line segment clipper.
// Holds default widths, register indexes and window reset values; no dependencies.
package lsc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } reg_idx_t;

    localparam int WIN_LEFT_RST   = -100;
    localparam int WIN_RIGHT_RST  = 100;
    localparam int WIN_BOTTOM_RST = -100;
    localparam int WIN_TOP_RST    = 100;

endpackage

FILE: rtl/lsc_select.sv
// Boundary selection stages of the clipper: edge distances, entering and leaving ratios.
// Six register stages; ratios are compared exactly by cross multiplication. Uses no package.
module lsc_select #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic signed [COORD_BITS-1:0] win_l,
    input  logic signed [COORD_BITS-1:0] win_r,
    input  logic signed [COORD_BITS-1:0] win_b,
    input  logic signed [COORD_BITS-1:0] win_t,
    output logic                         out_valid,
    output logic        [COORD_BITS-1:0] out_n1,
    output logic        [COORD_BITS-1:0] out_d1,
    output logic        [COORD_BITS-1:0] out_n2,
    output logic        [COORD_BITS-1:0] out_d2,
    output logic                         out_reject,
    output logic signed [COORD_BITS-1:0] out_x1,
    output logic signed [COORD_BITS-1:0] out_y1,
    output logic signed [COORD_BITS:0]   out_dx,
    output logic signed [COORD_BITS:0]   out_dy
);

    localparam int W  = COORD_BITS + 1;
    localparam int PW = 2 * W;

    localparam logic signed [W-1:0] ONE  = W'(1);
    localparam logic signed [W-1:0] ZERO = '0;

    logic [5:0] v_reg;

    // Stage 1: deltas and signed distances to each edge.
    logic signed [COORD_BITS-1:0] x1_1_reg, y1_1_reg;
    logic signed [W-1:0] dx_1_reg, dy_1_reg, ql_1_reg, qr_1_reg, qb_1_reg, qt_1_reg;

    // Stage 2: x axis already folded into the running entering and leaving ratios.
    logic signed [COORD_BITS-1:0] x1_2_reg, y1_2_reg;
    logic signed [W-1:0] dx_2_reg, dy_2_reg;
    logic signed [W-1:0] en_2_reg, ed_2_reg, ln_2_reg, ld_2_reg, eyn_2_reg, lyn_2_reg, ady_2_reg;
    logic yok_2_reg, par_2_reg;

    // Stage 3: cross products for the y axis candidates.
    logic signed [COORD_BITS-1:0] x1_3_reg, y1_3_reg;
    logic signed [W-1:0] dx_3_reg, dy_3_reg;
    logic signed [W-1:0] en_3_reg, ed_3_reg, ln_3_reg, ld_3_reg, eyn_3_reg, lyn_3_reg, ady_3_reg;
    logic yok_3_reg, par_3_reg;
    logic signed [PW-1:0] pey_3_reg, pex_3_reg, ply_3_reg, plx_3_reg;

    // Stage 4: final entering and leaving ratios.
    logic signed [COORD_BITS-1:0] x1_4_reg, y1_4_reg;
    logic signed [W-1:0] dx_4_reg, dy_4_reg, en_4_reg, ed_4_reg, ln_4_reg, ld_4_reg;
    logic par_4_reg;

    // Stage 5: cross products for the empty span test.
    logic signed [COORD_BITS-1:0] x1_5_reg, y1_5_reg;
    logic signed [W-1:0] dx_5_reg, dy_5_reg, en_5_reg, ed_5_reg, ln_5_reg, ld_5_reg;
    logic par_5_reg;
    logic signed [PW-1:0] pa_5_reg, pb_5_reg;

    logic signed [W-1:0] x1_e, y1_e;
    logic signed [W-1:0] en_c, ed_c, ln_c, ld_c, eyn_c, lyn_c, adx_c, ady_c, exn_c, lxn_c;
    logic dx_zero, dy_zero, dx_pos, dy_pos, take_ex, take_lx, par_c;
    logic take_ey, take_ly;

    assign x1_e = {x1[COORD_BITS-1], x1};
    assign y1_e = {y1[COORD_BITS-1], y1};

    always_comb
    begin
        dx_zero = (dx_1_reg == ZERO);
        dy_zero = (dy_1_reg == ZERO);
        dx_pos  = !dx_1_reg[W-1] && !dx_zero;
        dy_pos  = !dy_1_reg[W-1] && !dy_zero;
        adx_c   = dx_pos ? dx_1_reg : -dx_1_reg;
        ady_c   = dy_pos ? dy_1_reg : -dy_1_reg;
        exn_c   = dx_pos ? -ql_1_reg : -qr_1_reg;
        lxn_c   = dx_pos ? qr_1_reg : ql_1_reg;
        eyn_c   = dy_pos ? -qb_1_reg : -qt_1_reg;
        lyn_c   = dy_pos ? qt_1_reg : qb_1_reg;
        // Against the initial ratios 0 and 1 the compare needs no multiply.
        take_ex = !dx_zero && (exn_c > ZERO);
        take_lx = !dx_zero && (lxn_c < adx_c);
        en_c    = take_ex ? exn_c : ZERO;
        ed_c    = take_ex ? adx_c : ONE;
        ln_c    = take_lx ? lxn_c : ONE;
        ld_c    = take_lx ? adx_c : ONE;
        par_c   = (dx_zero && (ql_1_reg[W-1] || qr_1_reg[W-1]))
                || (dy_zero && (qb_1_reg[W-1] || qt_1_reg[W-1]));
    end

    assign take_ey = yok_3_reg && (pey_3_reg > pex_3_reg);
    assign take_ly = yok_3_reg && (ply_3_reg < plx_3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_1_reg <= x1;
        y1_1_reg <= y1;
        dx_1_reg <= {x2[COORD_BITS-1], x2} - x1_e;
        dy_1_reg <= {y2[COORD_BITS-1], y2} - y1_e;
        ql_1_reg <= x1_e - {win_l[COORD_BITS-1], win_l};
        qr_1_reg <= {win_r[COORD_BITS-1], win_r} - x1_e;
        qb_1_reg <= y1_e - {win_b[COORD_BITS-1], win_b};
        qt_1_reg <= {win_t[COORD_BITS-1], win_t} - y1_e;

        x1_2_reg  <= x1_1_reg;
        y1_2_reg  <= y1_1_reg;
        dx_2_reg  <= dx_1_reg;
        dy_2_reg  <= dy_1_reg;
        en_2_reg  <= en_c;
        ed_2_reg  <= ed_c;
        ln_2_reg  <= ln_c;
        ld_2_reg  <= ld_c;
        eyn_2_reg <= eyn_c;
        lyn_2_reg <= lyn_c;
        ady_2_reg <= ady_c;
        yok_2_reg <= !dy_zero;
        par_2_reg <= par_c;

        x1_3_reg  <= x1_2_reg;
        y1_3_reg  <= y1_2_reg;
        dx_3_reg  <= dx_2_reg;
        dy_3_reg  <= dy_2_reg;
        en_3_reg  <= en_2_reg;
        ed_3_reg  <= ed_2_reg;
        ln_3_reg  <= ln_2_reg;
        ld_3_reg  <= ld_2_reg;
        eyn_3_reg <= eyn_2_reg;
        lyn_3_reg <= lyn_2_reg;
        ady_3_reg <= ady_2_reg;
        yok_3_reg <= yok_2_reg;
        par_3_reg <= par_2_reg;
        pey_3_reg <= eyn_2_reg * ed_2_reg;
        pex_3_reg <= en_2_reg * ady_2_reg;
        ply_3_reg <= lyn_2_reg * ld_2_reg;
        plx_3_reg <= ln_2_reg * ady_2_reg;

        x1_4_reg  <= x1_3_reg;
        y1_4_reg  <= y1_3_reg;
        dx_4_reg  <= dx_3_reg;
        dy_4_reg  <= dy_3_reg;
        en_4_reg  <= take_ey ? eyn_3_reg : en_3_reg;
        ed_4_reg  <= take_ey ? ady_3_reg : ed_3_reg;
        ln_4_reg  <= take_ly ? lyn_3_reg : ln_3_reg;
        ld_4_reg  <= take_ly ? ady_3_reg : ld_3_reg;
        par_4_reg <= par_3_reg;

        x1_5_reg  <= x1_4_reg;
        y1_5_reg  <= y1_4_reg;
        dx_5_reg  <= dx_4_reg;
        dy_5_reg  <= dy_4_reg;
        en_5_reg  <= en_4_reg;
        ed_5_reg  <= ed_4_reg;
        ln_5_reg  <= ln_4_reg;
        ld_5_reg  <= ld_4_reg;
        par_5_reg <= par_4_reg;
        pa_5_reg  <= en_4_reg * ld_4_reg;
        pb_5_reg  <= ln_4_reg * ed_4_reg;

        // On a surviving segment both ratios lie in [0, 1], so the low bits suffice.
        out_n1     <= en_5_reg[COORD_BITS-1:0];
        out_d1     <= ed_5_reg[COORD_BITS-1:0];
        out_n2     <= ln_5_reg[COORD_BITS-1:0];
        out_d2     <= ld_5_reg[COORD_BITS-1:0];
        out_reject <= par_5_reg || (pa_5_reg > pb_5_reg);
        out_x1     <= x1_5_reg;
        out_y1     <= y1_5_reg;
        out_dx     <= dx_5_reg;
        out_dy     <= dy_5_reg;
    end

    assign out_valid = v_reg[5];

endmodule

FILE: rtl/lsc_div.sv
// Pipelined restoring divider for the two clip parameters, one quotient bit per stage.
// Gives floor((n * 2^FRAC_BITS + floor(d / 2)) / d) for n <= d; uses no package.
module lsc_div #(
    parameter int DEN_W     = 12,
    parameter int FRAC_BITS = 16,
    parameter int PAY_W     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [DEN_W-1:0]     n1,
    input  logic [DEN_W-1:0]     d1,
    input  logic [DEN_W-1:0]     n2,
    input  logic [DEN_W-1:0]     d2,
    input  logic [PAY_W-1:0]     in_pay,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   u1,
    output logic [FRAC_BITS:0]   u2,
    output logic [PAY_W-1:0]     out_pay
);

    localparam int NS = FRAC_BITS + 1;
    localparam int RW = DEN_W + 1;
    localparam int QW = FRAC_BITS + 1;

    logic [NS-1:0]    v_reg;
    logic [RW-1:0]    r_reg [NS][2];
    logic [QW-1:0]    q_reg [NS][2];
    logic [DEN_W-1:0] d_reg [NS][2];
    logic [PAY_W-1:0] pay_reg [NS];

    logic [RW-1:0]    r_try [NS][2];
    logic [QW-1:0]    q_in  [NS][2];
    logic [DEN_W-1:0] d_in  [NS][2];
    logic             qbit  [NS][2];

    logic [RW-1:0]    sum_fix [2];
    logic             out_v_reg;

    genvar s, k;

    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            for (k = 0; k < 2; k++)
            begin : g_lane
                if (s == 0)
                begin : g_first
                    assign r_try[s][k] = (k == 0) ? {1'b0, n1} : {1'b0, n2};
                    assign d_in[s][k]  = (k == 0) ? d1 : d2;
                    assign q_in[s][k]  = '0;
                end
                else
                begin : g_next
                    assign r_try[s][k] = {r_reg[s-1][k][DEN_W-1:0], 1'b0};
                    assign d_in[s][k]  = d_reg[s-1][k];
                    assign q_in[s][k]  = q_reg[s-1][k];
                end

                assign qbit[s][k] = (r_try[s][k] >= {1'b0, d_in[s][k]});

                always_ff @(posedge clk)
                begin
                    r_reg[s][k] <= qbit[s][k] ? (r_try[s][k] - {1'b0, d_in[s][k]})
                                              : r_try[s][k];
                    q_reg[s][k] <= {q_in[s][k][QW-2:0], qbit[s][k]};
                    d_reg[s][k] <= d_in[s][k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (s == 0)
                begin
                    pay_reg[s] <= in_pay;
                end
                else
                begin
                    pay_reg[s] <= pay_reg[(s == 0) ? 0 : s-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[NS-2:0], in_valid};
            out_v_reg <= v_reg[NS-1];
        end
    end

    // The half divisor is added after the long division: remainder plus half stays below 2d.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sum_fix[i] = r_reg[NS-1][i] + {2'b00, d_reg[NS-1][i][DEN_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        u1      <= q_reg[NS-1][0] + QW'(sum_fix[0] >= {1'b0, d_reg[NS-1][0]});
        u2      <= q_reg[NS-1][1] + QW'(sum_fix[1] >= {1'b0, d_reg[NS-1][1]});
        out_pay <= pay_reg[NS-1];
    end

    assign out_valid = out_v_reg;

endmodule

FILE: rtl/lsc_interp.sv
// Endpoint interpolation of the clipper: start + u * delta, rounded half up.
// Two register stages, four multipliers; uses no package.
module lsc_interp #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic        [FRAC_BITS:0]    u1,
    input  logic        [FRAC_BITS:0]    u2,
    input  logic                         reject,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS:0]   dx,
    input  logic signed [COORD_BITS:0]   dy,
    output logic                         done,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);

    localparam int W  = COORD_BITS + 1;
    localparam int MW = FRAC_BITS + 2 + W;
    localparam logic signed [MW-1:0] HALF = MW'(2 ** (FRAC_BITS - 1));

    logic                         v_reg;
    logic                         rej_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic signed [MW-1:0]         m_reg [4];
    logic signed [MW-1:0]         sh    [4];
    logic signed [COORD_BITS-1:0] res   [4];
    logic signed [FRAC_BITS+1:0]  su1, su2;

    assign su1 = $signed({1'b0, u1});
    assign su2 = $signed({1'b0, u2});

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // Arithmetic shift of a two's complement value is a floor.
            sh[i] = (m_reg[i] + HALF) >>> FRAC_BITS;
        end
        res[0] = sh[0][COORD_BITS-1:0] + x1_reg;
        res[1] = sh[1][COORD_BITS-1:0] + y1_reg;
        res[2] = sh[2][COORD_BITS-1:0] + x1_reg;
        res[3] = sh[3][COORD_BITS-1:0] + y1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
            done  <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
            done  <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= su1 * dx;
        m_reg[1] <= su1 * dy;
        m_reg[2] <= su2 * dx;
        m_reg[3] <= su2 * dy;
        rej_reg  <= reject;
        x1_reg   <= x1;
        y1_reg   <= y1;

        visible      <= !rej_reg;
        clip_start_x <= rej_reg ? '0 : res[0];
        clip_start_y <= rej_reg ? '0 : res[1];
        clip_end_x   <= rej_reg ? '0 : res[2];
        clip_end_y   <= rej_reg ? '0 : res[3];
    end

endmodule

FILE: rtl/line_segment_clipper_core.sv
// Line segment clipper core: window registers, selection, division and interpolation pipeline.
// Depends on lsc_pkg, lsc_select, lsc_div and lsc_interp.
// Throughput: one item per cycle; busy stays low, set by the fully pipelined divider.
// Reset clears all valid bits and loads the window to -100..100 on both axes.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
module line_segment_clipper_core #(
    parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lsc_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         done,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);

    localparam int W       = COORD_BITS + 1;
    localparam int PAY_W   = 1 + 2 * COORD_BITS + 2 * W;
    localparam int LATENCY = FRAC_BITS + 10;

    logic signed [COORD_BITS-1:0] win_left_reg, win_right_reg, win_bottom_reg, win_top_reg;
    lsc_pkg::reg_idx_t            reg_idx;
    logic                         wr_en;

    logic                         sel_valid, sel_reject;
    logic        [COORD_BITS-1:0] sel_n1, sel_d1, sel_n2, sel_d2;
    logic signed [COORD_BITS-1:0] sel_x1, sel_y1;
    logic signed [W-1:0]          sel_dx, sel_dy;

    logic                         div_valid;
    logic        [FRAC_BITS:0]    div_u1, div_u2;
    logic        [PAY_W-1:0]      div_pay;

    assign reg_idx = lsc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= COORD_BITS'(lsc_pkg::WIN_LEFT_RST);
            win_right_reg  <= COORD_BITS'(lsc_pkg::WIN_RIGHT_RST);
            win_bottom_reg <= COORD_BITS'(lsc_pkg::WIN_BOTTOM_RST);
            win_top_reg    <= COORD_BITS'(lsc_pkg::WIN_TOP_RST);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lsc_pkg::REG_LEFT:   win_left_reg   <= pwdata[COORD_BITS-1:0];
                lsc_pkg::REG_RIGHT:  win_right_reg  <= pwdata[COORD_BITS-1:0];
                lsc_pkg::REG_BOTTOM: win_bottom_reg <= pwdata[COORD_BITS-1:0];
                lsc_pkg::REG_TOP:    win_top_reg    <= pwdata[COORD_BITS-1:0];
                default:             win_left_reg   <= win_left_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lsc_pkg::REG_LEFT:
                prdata = {{(32-COORD_BITS){win_left_reg[COORD_BITS-1]}}, win_left_reg};
            lsc_pkg::REG_RIGHT:
                prdata = {{(32-COORD_BITS){win_right_reg[COORD_BITS-1]}}, win_right_reg};
            lsc_pkg::REG_BOTTOM:
                prdata = {{(32-COORD_BITS){win_bottom_reg[COORD_BITS-1]}}, win_bottom_reg};
            lsc_pkg::REG_TOP:
                prdata = {{(32-COORD_BITS){win_top_reg[COORD_BITS-1]}}, win_top_reg};
            default:
                prdata = '0;
        endcase
    end

    lsc_select #(
        .COORD_BITS (COORD_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .x1         (start_x),
        .y1         (start_y),
        .x2         (end_x),
        .y2         (end_y),
        .win_l      (win_left_reg),
        .win_r      (win_right_reg),
        .win_b      (win_bottom_reg),
        .win_t      (win_top_reg),
        .out_valid  (sel_valid),
        .out_n1     (sel_n1),
        .out_d1     (sel_d1),
        .out_n2     (sel_n2),
        .out_d2     (sel_d2),
        .out_reject (sel_reject),
        .out_x1     (sel_x1),
        .out_y1     (sel_y1),
        .out_dx     (sel_dx),
        .out_dy     (sel_dy)
    );

    lsc_div #(
        .DEN_W     (COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .PAY_W     (PAY_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .n1        (sel_n1),
        .d1        (sel_d1),
        .n2        (sel_n2),
        .d2        (sel_d2),
        .in_pay    ({sel_reject, sel_x1, sel_y1, sel_dx, sel_dy}),
        .out_valid (div_valid),
        .u1        (div_u1),
        .u2        (div_u2),
        .out_pay   (div_pay)
    );

    lsc_interp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .u1           (div_u1),
        .u2           (div_u2),
        .reject       (div_pay[PAY_W-1]),
        .x1           (div_pay[PAY_W-2 -: COORD_BITS]),
        .y1           (div_pay[PAY_W-2-COORD_BITS -: COORD_BITS]),
        .dx           (div_pay[2*W-1 -: W]),
        .dy           (div_pay[W-1:0]),
        .done         (done),
        .visible      (visible),
        .clip_start_x (clip_start_x),
        .clip_start_y (clip_start_y),
        .clip_end_x   (clip_end_x),
        .clip_end_y   (clip_end_y)
    );

    // A rejected item must carry all-zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !visible) |-> (clip_start_x == '0 && clip_start_y == '0
                                && clip_end_x == '0 && clip_end_y == '0))
        else $error("rejected item has nonzero coordinates");

    // Every accepted item comes out a fixed number of cycles later.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not complete on time");

    // The core never holds off an item or a register access.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && pready))
        else $error("busy high or pready low");

endmodule

FILE: sim/line_segment_clipper_core_test.sv
// Self-checking testbench for the line segment clipper core.
// Drives segments and APB window writes, and checks results against a built-in predictor.
// Depends on lsc_pkg and line_segment_clipper_core.
`timescale 1ns / 100ps

module line_segment_clipper_core_test;

    localparam int CB = lsc_pkg::COORD_BITS_DEF;
    localparam int FB = lsc_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = FB + 10;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        logic   vis;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } clip_t;

    typedef struct {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        logic   known;
        clip_t  res;
    } seg_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    coord_t      start_x = '0;
    coord_t      start_y = '0;
    coord_t      end_x = '0;
    coord_t      end_y = '0;
    logic        done;
    logic        visible;
    coord_t      clip_start_x;
    coord_t      clip_start_y;
    coord_t      clip_end_x;
    coord_t      clip_end_y;

    coord_t win_left, win_right, win_bottom, win_top;
    clip_t  pending_clips[$];
    int     fail_count = 0;
    int     result_count = 0;
    int     item_count = 0;
    int     visible_count = 0;
    longint cycle_count = 0;

    line_segment_clipper_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .done(done), .visible(visible),
        .clip_start_x(clip_start_x), .clip_start_y(clip_start_y),
        .clip_end_x(clip_end_x), .clip_end_y(clip_end_y)
    );

    always #4 clk = ~clk;

    // Rounds num/den to Q1.FB, ties upward; den is always positive here.
    function automatic longint to_param(longint num, longint den);
        return (num * (longint'(1) << FB) + den / 2) / den;
    endfunction

    function automatic coord_t interp(longint base, longint u, longint delta);
        longint v;
        longint f;
        v = u * delta + (longint'(1) << (FB - 1));
        f = v >>> FB;
        return coord_t'(base + f);
    endfunction

    function automatic clip_t clip_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
        longint p[4];
        longint q[4];
        longint dx, dy, n1, d1, n2, d2, n, d, u1, u2;
        logic   rej;
        clip_t  r;
        dx = longint'(x2) - longint'(x1);
        dy = longint'(y2) - longint'(y1);
        n1 = 0; d1 = 1; n2 = 1; d2 = 1;
        rej = 1'b0;
        p[0] = -dx; q[0] = longint'(x1) - longint'(win_left);
        p[1] = dx;  q[1] = longint'(win_right) - longint'(x1);
        p[2] = -dy; q[2] = longint'(y1) - longint'(win_bottom);
        p[3] = dy;  q[3] = longint'(win_top) - longint'(y1);
        for (int i = 0; i < 4; i++)
        begin
            if (p[i] == 0)
            begin
                if (q[i] < 0)
                    rej = 1'b1;
            end
            else if (p[i] < 0)
            begin
                n = -q[i]; d = -p[i];
                if (n * d1 > n1 * d)
                begin
                    n1 = n; d1 = d;
                end
            end
            else
            begin
                n = q[i]; d = p[i];
                if (n * d2 < n2 * d)
                begin
                    n2 = n; d2 = d;
                end
            end
        end
        if (n1 * d2 > n2 * d1)
            rej = 1'b1;
        r = '0;
        if (!rej)
        begin
            u1 = to_param(n1, d1);
            u2 = to_param(n2, d2);
            r.vis = 1'b1;
            r.sx = interp(x1, u1, dx);
            r.sy = interp(y1, u1, dy);
            r.ex = interp(x1, u2, dx);
            r.ey = interp(y1, u2, dy);
        end
        return r;
    endfunction

    // Result monitor: the receiver cannot stall, so every done cycle is checked.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            clip_t got, want;
            got = '{visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y};
            result_count <= result_count + 1;
            if (pending_clips.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = pending_clips.pop_front();
                if (got.vis) visible_count <= visible_count + 1;
                if (got.vis !== want.vis)
                    $error("visible: expected %0d actual %0d", want.vis, got.vis);
                if (got.sx !== want.sx)
                    $error("clip_start_x: expected %0d actual %0d", want.sx, got.sx);
                if (got.sy !== want.sy)
                    $error("clip_start_y: expected %0d actual %0d", want.sy, got.sy);
                if (got.ex !== want.ex)
                    $error("clip_end_x: expected %0d actual %0d", want.ex, got.ex);
                if (got.ey !== want.ey)
                    $error("clip_end_y: expected %0d actual %0d", want.ey, got.ey);
                if (got !== want)
                    fail_count <= fail_count + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** line_segment_clipper_core: FAILED **");
            $finish;
        end
    end

    task automatic write_window(lsc_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            lsc_pkg::REG_LEFT:   win_left = coord_t'(value);
            lsc_pkg::REG_RIGHT:  win_right = coord_t'(value);
            lsc_pkg::REG_BOTTOM: win_bottom = coord_t'(value);
            lsc_pkg::REG_TOP:    win_top = coord_t'(value);
            default: ;
        endcase
    endtask

    task automatic set_window(int l, int r, int b, int t);
        write_window(lsc_pkg::REG_LEFT, l);
        write_window(lsc_pkg::REG_RIGHT, r);
        write_window(lsc_pkg::REG_BOTTOM, b);
        write_window(lsc_pkg::REG_TOP, t);
    endtask

    // Waits until every expected result has come back, plus the pipeline depth.
    task automatic drain();
        while (pending_clips.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Presents one item at the falling edge; start stays high across back-to-back items.
    task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                                logic known, clip_t res, logic may_idle);
        clip_t want;
        // Each cycle idles with the same odds, so the idle share stays near 31 percent.
        while (may_idle && $urandom_range(99) < 31)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        start_x = x1; start_y = y1; end_x = x2; end_y = y2;
        want = clip_segment(x1, y1, x2, y2);
        if (known && res !== want)
        begin
            $error("table row disagrees with predictor");
            fail_count++;
        end
        do @(posedge clk); while (busy);
        pending_clips.push_back(want);
        item_count++;
        @(negedge clk);
    endtask

    task automatic random_items(int count, logic may_idle, int wmax);
        coord_t a, b, c, d;
        int     shape;
        for (int i = 0; i < count; i++)
        begin
            shape = $urandom_range(9);
            a = coord_t'($urandom); b = coord_t'($urandom);
            c = coord_t'($urandom); d = coord_t'($urandom);
            if (shape < 5)
            begin
                // Half the items lie near the window so clipping actually happens.
                a = coord_t'($urandom_range(0, 2 * wmax) - wmax);
                b = coord_t'($urandom_range(0, 2 * wmax) - wmax);
                c = coord_t'($urandom_range(0, 2 * wmax) - wmax);
                d = coord_t'($urandom_range(0, 2 * wmax) - wmax);
            end
            else if (shape == 5)
                c = a;
            else if (shape == 6)
                d = b;
            else if (shape == 7)
            begin
                c = a; d = b;
            end
            send_segment(a, b, c, d, 1'b0, '0, may_idle);
        end
        start = 1'b0;
    endtask

    seg_row_t seg_table[$];

    initial
    begin
        win_left = coord_t'(lsc_pkg::WIN_LEFT_RST);
        win_right = coord_t'(lsc_pkg::WIN_RIGHT_RST);
        win_bottom = coord_t'(lsc_pkg::WIN_BOTTOM_RST);
        win_top = coord_t'(lsc_pkg::WIN_TOP_RST);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset window: -100..100 on both axes.
        seg_table = '{
            '{0, 0, 50, 50, 1, '{1, 0, 0, 50, 50}},
            '{-200, 0, 200, 0, 1, '{1, -100, 0, 100, 0}},
            '{0, -200, 0, 200, 1, '{1, 0, -100, 0, 100}},
            '{200, 200, 300, 300, 1, '{0, 0, 0, 0, 0}},
            '{-2048, -2048, 2047, 2047, 1, '{1, -100, -100, 100, 100}},
            '{2047, -2048, -2048, 2047, 0, '{0, 0, 0, 0, 0}},
            '{-2048, 50, 2047, 50, 1, '{1, -100, 50, 100, 50}},
            '{-2048, 150, 2047, 150, 1, '{0, 0, 0, 0, 0}},
            '{150, -2048, 150, 2047, 1, '{0, 0, 0, 0, 0}},
            '{7, 9, 7, 9, 1, '{1, 7, 9, 7, 9}},
            '{100, -100, 100, -100, 1, '{1, 100, -100, 100, -100}},
            '{101, 0, 101, 0, 1, '{0, 0, 0, 0, 0}},
            '{-150, 0, 0, 150, 0, '{0, 0, 0, 0, 0}},
            '{-300, 0, 0, 300, 0, '{0, 0, 0, 0, 0}},
            '{-2047, 3, 2047, -5, 0, '{0, 0, 0, 0, 0}},
            '{0, 0, 1, 2, 0, '{0, 0, 0, 0, 0}},
            '{-1, 0, 0, 0, 1, '{1, -1, 0, 0, 0}}
        };
        foreach (seg_table[i])
            send_segment(seg_table[i].x1, seg_table[i].y1, seg_table[i].x2, seg_table[i].y2,
                         seg_table[i].known, seg_table[i].res, 1'b0);
        start = 1'b0;
        drain();

        // Inverted window rejects everything.
        set_window(10, -10, -50, 50);
        send_segment(0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}, 1'b0);
        send_segment(-500, 0, 500, 0, 1, '{0, 0, 0, 0, 0}, 1'b0);
        start = 1'b0;
        drain();

        // Full range window, no idling.
        set_window(-2048, 2047, -2048, 2047);
        random_items(150, 1'b0, 2047);
        drain();
        set_window(-100, 100, -100, 100);
        random_items(150, 1'b1, 300);
        drain();
        set_window(-3, 5, 0, 0);
        random_items(150, 1'b1, 12);
        drain();
        set_window($urandom_range(0, 1000) - 1200, $urandom_range(0, 1200),
                   $urandom_range(0, 1000) - 1200, $urandom_range(0, 1200));
        random_items(150, 1'b1, 2047);
        drain();
        set_window(2047, 2047, -2048, -2048);
        random_items(30, 1'b1, 2047);
        drain();

        $display("%0d items sent across seven window settings, %0d results, %0d visible",
                 item_count, result_count, visible_count);
        if (fail_count == 0)
            $display("** line_segment_clipper_core: PASSED **");
        else
            $display("** line_segment_clipper_core: FAILED **");
        $finish;
    end

endmodule
